[hw/rtl/mtsm_pkg.sv]
package mtsm_pkg;

    localparam int LEVEL_W = 8;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_SUB   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CMD_HOLD        = 2'd0,
        CMD_INSERT      = 2'd1,
        CMD_INSERT_FULL = 2'd2,
        CMD_REMOVE      = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [LEVEL_W-1:0] v;
    } cell_bcast_t;

    typedef struct packed {
        logic occ;
        logic at_end;
    } cell_ctrl_t;

endpackage

[hw/rtl/mtsm_cell.sv]
module mtsm_cell (
    input  logic                               clk,
    input  mtsm_pkg::cell_bcast_t              bc,
    input  mtsm_pkg::cell_ctrl_t               ctrl,
    input  logic [mtsm_pkg::LEVEL_W-1:0]       left_val,
    input  logic                               left_gt,
    input  logic [mtsm_pkg::LEVEL_W-1:0]       right_val,
    input  logic                               right_gt,
    output logic [mtsm_pkg::LEVEL_W-1:0]       val,
    output logic                               gt,
    output logic                               ge
);
    import mtsm_pkg::*;

    logic [LEVEL_W-1:0] val_reg;
    logic [LEVEL_W-1:0] val_next;

    assign gt  = ctrl.occ && (val_reg > bc.v);
    assign ge  = ctrl.occ && (val_reg >= bc.v);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        unique case (bc.cmd)
            CMD_INSERT:
            begin
                if (gt || ctrl.at_end)
                begin
                    val_next = left_gt ? left_val : bc.v;
                end
            end
            CMD_INSERT_FULL:
            begin
                if (!right_gt)
                begin
                    val_next = right_val;
                end
                else if (!gt)
                begin
                    val_next = bc.v;
                end
            end
            CMD_REMOVE:
            begin
                if (ge)
                begin
                    val_next = right_val;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[hw/rtl/max_tracking_sorted_multiset.sv]
// Max-tracking sorted multiset of 8-bit levels.
// The input channel (in_valid, in_ready, op, level) takes one operation per
// item: clear, add a level, or subtract a level. The output channel
// (out_valid, out_ready, current_max, stored_count, overflow) returns one
// result item per input item, showing the state after that operation.
// The largest level sits in its own register; the other levels sit in a row
// of cells kept in ascending order. Every cell compares its entry with the
// broadcast level and shifts in a neighbor's entry or the new level in the
// same cycle, so no operation has to step through the row entry by entry.
// The result is registered and valid in the cycle after acceptance.
// Throughput is one item per cycle while the receiver keeps out_ready high.
// The state registers double as the output register, so while a result
// waits for out_ready the block holds in_ready low and accepts nothing.
// Reset empties the set and clears out_valid; the stored entries themselves
// are not cleared, since only entries below the fill count are ever used.
// When the store is full an add drops the smallest of the stored entries and the new one, and sets overflow.
module max_tracking_sorted_multiset #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          op,
    input  logic [mtsm_pkg::LEVEL_W-1:0]        level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mtsm_pkg::LEVEL_W-1:0]        current_max,
    output logic [mtsm_pkg::COUNT_OUT_W-1:0]    stored_count,
    output logic                                overflow
);
    import mtsm_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [LEVEL_W-1:0] max_reg;
    logic [LEVEL_W-1:0] max_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               out_valid_reg;
    logic               accept;
    logic               full;
    logic               found;
    logic [LEVEL_W-1:0] top_val;
    cell_cmd_t          cmd;
    logic [LEVEL_W-1:0] v;
    cell_bcast_t        bc;

    logic [LEVEL_W-1:0] vals [CAPACITY];
    logic [CAPACITY-1:0] gts;
    logic [CAPACITY-1:0] ges;
    logic [CAPACITY-1:0] tops;

    assign in_ready     = !out_valid_reg || out_ready;
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign current_max  = max_reg;
    assign stored_count = COUNT_OUT_W'(count_reg);
    assign overflow     = ovf_reg;
    assign full         = (count_reg == CNT_W'(CAPACITY));
    assign found        = |ges;

    assign bc.cmd = accept ? cmd : CMD_HOLD;
    assign bc.v   = v;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_ctrl_t          ctrl;
            logic [LEVEL_W-1:0]  lv;
            logic                lg;
            logic [LEVEL_W-1:0]  rv;
            logic                rg;

            assign ctrl.occ    = (count_reg > CNT_W'(i));
            assign ctrl.at_end = (count_reg == CNT_W'(i));
            assign tops[i]     = (count_reg == CNT_W'(i + 1));

            if (i == 0)
            begin : g_first
                assign lv = v;
                assign lg = 1'b0;
            end
            else
            begin : g_inner_l
                assign lv = vals[i-1];
                assign lg = gts[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign rv = vals[i];
                assign rg = 1'b1;
            end
            else
            begin : g_inner_r
                assign rv = vals[i+1];
                assign rg = gts[i+1];
            end

            mtsm_cell u_cell (
                .clk       (clk),
                .bc        (bc),
                .ctrl      (ctrl),
                .left_val  (lv),
                .left_gt   (lg),
                .right_val (rv),
                .right_gt  (rg),
                .val       (vals[i]),
                .gt        (gts[i]),
                .ge        (ges[i])
            );
        end
    endgenerate

    always_comb
    begin
        top_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            top_val = top_val | (tops[i] ? vals[i] : '0);
        end
    end

    always_comb
    begin
        cmd        = CMD_HOLD;
        v          = level;
        max_next   = max_reg;
        count_next = count_reg;
        ovf_next   = 1'b0;
        unique case (op_t'(op))
            OP_CLEAR:
            begin
                max_next   = '0;
                count_next = '0;
            end
            OP_ADD:
            begin
                if (level != '0)
                begin
                    if (max_reg == '0)
                    begin
                        max_next = level;
                    end
                    else
                    begin
                        if (level > max_reg)
                        begin
                            v        = max_reg;
                            max_next = level;
                        end
                        if (full)
                        begin
                            cmd      = CMD_INSERT_FULL;
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            cmd        = CMD_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            OP_SUB:
            begin
                if (level != '0 && max_reg != '0)
                begin
                    if (level >= max_reg)
                    begin
                        if (count_reg == '0)
                        begin
                            max_next = '0;
                        end
                        else
                        begin
                            max_next   = top_val;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    else if (found)
                    begin
                        cmd        = CMD_REMOVE;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                cmd = CMD_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                max_reg       <= max_next;
                count_reg     <= count_next;
                ovf_reg       <= ovf_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_empty_max: assert property (@(posedge clk) disable iff (!rst_n)
        (max_reg == '0) |-> (count_reg == '0))
        else $error("levels stored while maximum is zero");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("overflow flagged with store not full");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_CLEAR) |=> (max_reg == '0 && count_reg == '0))
        else $error("clear did not empty the set");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted item produced no result");

endmodule

[dv/max_tracking_sorted_multiset_checker.sv]
`timescale 1ns / 1ps

module max_tracking_sorted_multiset_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [1:0]                       op,
    input  logic [mtsm_pkg::LEVEL_W-1:0]     level,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [mtsm_pkg::LEVEL_W-1:0]     current_max,
    input  logic [mtsm_pkg::COUNT_OUT_W-1:0] stored_count,
    input  logic                             overflow,
    output int                               mismatches,
    output int                               outstanding,
    output int                               checked,
    output int                               overflows
);
    import mtsm_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0]     peak;
        logic [COUNT_OUT_W-1:0] fill;
        logic                   spill;
    } level_summary_t;

    logic [LEVEL_W-1:0] peak_level = '0;
    logic [LEVEL_W-1:0] ordered_levels [CAPACITY];
    int unsigned        held_count = 0;
    level_summary_t     pending_summaries [$];

    function automatic logic insert_ordered(input logic [LEVEL_W-1:0] v);
        logic [LEVEL_W-1:0] row [CAPACITY+1];
        int unsigned        n;
        int unsigned        pos;
        n = held_count;
        for (int i = 0; i < n; i++)
        begin
            row[i] = ordered_levels[i];
        end
        pos = n;
        while (pos > 0 && row[pos-1] > v)
        begin
            row[pos] = row[pos-1];
            pos--;
        end
        row[pos] = v;
        n++;
        if (n > CAPACITY)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                ordered_levels[i] = row[i+1];
            end
            held_count = CAPACITY;
            return 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            ordered_levels[i] = row[i];
        end
        held_count = n;
        return 1'b0;
    endfunction

    function automatic level_summary_t apply_level_op(input logic [1:0] code,
                                                      input logic [LEVEL_W-1:0] lv);
        level_summary_t     s;
        logic               dropped;
        logic [LEVEL_W-1:0] low;
        int                 hit;
        dropped = 1'b0;
        case (op_t'(code))
            OP_CLEAR:
            begin
                peak_level = '0;
                held_count = 0;
            end
            OP_ADD:
            begin
                if (lv != 0)
                begin
                    if (peak_level == 0)
                    begin
                        peak_level = lv;
                    end
                    else
                    begin
                        low = lv;
                        if (lv > peak_level)
                        begin
                            low = peak_level;
                            peak_level = lv;
                        end
                        dropped = insert_ordered(low);
                    end
                end
            end
            OP_SUB:
            begin
                if (lv != 0 && peak_level != 0)
                begin
                    if (lv >= peak_level)
                    begin
                        if (held_count == 0)
                        begin
                            peak_level = '0;
                        end
                        else
                        begin
                            peak_level = ordered_levels[held_count-1];
                            held_count--;
                        end
                    end
                    else
                    begin
                        hit = -1;
                        for (int i = 0; i < held_count; i++)
                        begin
                            if (hit < 0 && ordered_levels[i] >= lv)
                            begin
                                hit = i;
                            end
                        end
                        if (hit >= 0)
                        begin
                            for (int i = hit; i + 1 < held_count; i++)
                            begin
                                ordered_levels[i] = ordered_levels[i+1];
                            end
                            held_count--;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        s.peak = peak_level;
        s.fill = held_count[COUNT_OUT_W-1:0];
        s.spill = dropped;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        level_summary_t want;
        level_summary_t fresh;
        if (!rst_n)
        begin
            peak_level = '0;
            held_count = 0;
            pending_summaries.delete();
            mismatches = 0;
            checked = 0;
            overflows = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                fresh = apply_level_op(op, level);
                pending_summaries = {pending_summaries, fresh};
            end
            if (out_valid && out_ready)
            begin
                if (pending_summaries.size() == 0)
                begin
                    $error("result arrived with no operation pending");
                    mismatches++;
                end
                else
                begin
                    want = pending_summaries.pop_front();
                    checked++;
                    if (want.spill)
                    begin
                        overflows++;
                    end
                    if (current_max !== want.peak)
                    begin
                        $error("current_max: expected %0d, actual %0d", want.peak,
                               current_max);
                        mismatches++;
                    end
                    if (stored_count !== want.fill)
                    begin
                        $error("stored_count: expected %0d, actual %0d", want.fill,
                               stored_count);
                        mismatches++;
                    end
                    if (overflow !== want.spill)
                    begin
                        $error("overflow: expected %0d, actual %0d", want.spill,
                               overflow);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = pending_summaries.size();
    end

endmodule

[dv/max_tracking_sorted_multiset_tb.sv]
`timescale 1ns / 1ps

module max_tracking_sorted_multiset_tb;
    import mtsm_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_OPS = 550;
    localparam int CALM_OPS = 60;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             op = OP_CLEAR;
    logic [LEVEL_W-1:0]     level = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [LEVEL_W-1:0]     current_max;
    logic [COUNT_OUT_W-1:0] stored_count;
    logic                   overflow;

    int mismatches;
    int outstanding;
    int checked;
    int overflows;
    int sent_ops = 0;
    bit idle_on = 1'b1;
    bit calm = 1'b0;
    int stall_left = 0;

    always #6 clk = ~clk;

    max_tracking_sorted_multiset i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .level        (level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .current_max  (current_max),
        .stored_count (stored_count),
        .overflow     (overflow)
    );

    max_tracking_sorted_multiset_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .level        (level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .current_max  (current_max),
        .stored_count (stored_count),
        .overflow     (overflow),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked),
        .overflows    (overflows)
    );

    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (rst_n && !calm && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_level_op(input logic [1:0] code, input logic [LEVEL_W-1:0] lv);
        int gap;
        if (!calm && idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= code;
        level <= lv;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_ops++;
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 8'd255;
            2, 3:    return 8'($urandom_range(1, 8) * 32 - 1);
            4:       return 8'($urandom_range(1, 6));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int add_weight;
        int roll;
        logic [1:0] code;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_level_op(OP_CLEAR, 8'd0);
        send_level_op(OP_ADD, 8'd0);
        send_level_op(OP_SUB, 8'd9);
        send_level_op(OP_ADD, 8'd255);
        send_level_op(OP_ADD, 8'd1);
        send_level_op(OP_SUB, 8'd0);
        send_level_op(OP_SUB, 8'd200);
        send_level_op(OP_SUB, 8'd255);
        send_level_op(OP_UNUSED, 8'd170);
        for (int k = 17; k >= 1; k--) begin
            send_level_op(OP_ADD, 8'(k * 15));
        end
        send_level_op(OP_ADD, 8'd1);
        send_level_op(OP_UNUSED, 8'd85);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 60 == 0) begin
                idle_on = ($urandom_range(0, 2) != 0);
            end
            calm = (n >= RANDOM_OPS - CALM_OPS);
            add_weight = ((n / 60) % 2 == 0) ? 75 : 35;
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                code = OP_CLEAR;
            end
            else if (roll < 3) begin
                code = OP_UNUSED;
            end
            else if (roll < 3 + add_weight) begin
                code = OP_ADD;
            end
            else begin
                code = OP_SUB;
            end
            send_level_op(code, pick_level());
        end
        in_valid <= 1'b0;

        while (outstanding != 0) @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Sent %0d operations covering clear, add, subtract and the unused code;",
                 sent_ops);
        $display("checked %0d results, %0d of them with the store overflowing.",
                 checked, overflows);
        if (mismatches == 0) begin
            $display("[max_tracking_sorted_multiset] OK");
        end
        else begin
            $display("[max_tracking_sorted_multiset] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[max_tracking_sorted_multiset] ERROR");
        $finish;
    end

endmodule
